>>> sv/fmo_pkg.sv
// ----------------------------------------------------------------------------
// fmo_pkg
// Shared widths, codes and the quarter-wave sine table generator for the
// multi-voice FM oscillator.
// ----------------------------------------------------------------------------
package fmo_pkg;

	localparam int PHASE_W   = 24;
	localparam int SAMPLE_W  = 16;
	localparam int AMP_W     = 7;
	localparam int INDEX_W   = 6;
	localparam int NVOICE_W  = 6;
	localparam int VIDX_W    = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 7;
	localparam int ROM_W     = 15;

	// input word function codes
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_LOAD = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_USE_FM     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MOD_INDEX  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AMP        = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_VOICES = 2'd3;

	localparam logic [AMP_W-1:0]    AMP_RESET    = 7'd20;
	localparam logic [NVOICE_W-1:0] NVOICE_RESET = 6'd1;

	// phase units per radian, 2^24 / (2 pi)
	localparam logic signed [22:0] TURN_PER_RADIAN = 23'sd2670177;
	localparam longint unsigned    HALF_PI_Q30     = 64'd1686629713;

	// Quarter-wave entry k in Q15: Taylor series of sin in Q30, Horner form
	function automatic logic [ROM_W-1:0] quarter_rom(input int unsigned k,
		input int unsigned tbits);
		logic [63:0] one;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] p;
		logic [63:0] v;
		one = 64'd1 << 30;
		x   = (64'(k) * HALF_PI_Q30) >> (tbits - 2);
		x2  = (x * x) >> 30;
		p   = one - x2 / 64'd72;
		p   = one - (((x2 / 64'd42) * p) >> 30);
		p   = one - (((x2 / 64'd20) * p) >> 30);
		p   = one - (((x2 / 64'd6) * p) >> 30);
		v   = (x * p) >> 30;
		v   = (v + (64'd1 << 14)) >> 15;
		if (v > 64'd32767)
			v = 64'd32767;
		return v[ROM_W-1:0];
	endfunction

endpackage

>>> sv/multi_voice_fm_oscillator.sv
// ----------------------------------------------------------------------------
// multi_voice_fm_oscillator
// Multi-voice two-operator FM oscillator: voice state in synchronous memories,
// one voice per cycle through a read-modify-write pipeline, then a scaler.
// ----------------------------------------------------------------------------
// A load word writes one voice's carrier and modulator steps and leaves the
// input open. A tick word streams the active voices through a six-stage pipeline,
// one voice per cycle, reading and writing back the phase memory; the input
// then stalls until the pipeline has drained and the divider is free. The sum
// goes to a bit-serial divider that overlaps the next tick, so a new tick can
// be taken while the last sum is still being divided. Voice memories need no
// clearing pass after reset: a valid bit per entry makes unwritten entries read
// as zero. A finished sample waits in an output register while the next word
// is taken.
module multi_voice_fm_oscillator #(
	parameter int MAX_VOICES      = 32,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 func,
	input  logic [fmo_pkg::VIDX_W-1:0]           voice_index,
	input  logic [fmo_pkg::PHASE_W-1:0]          carrier_step,
	input  logic [fmo_pkg::PHASE_W-1:0]          mod_step,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [fmo_pkg::SAMPLE_W-1:0]  sample,
	input  logic                                 wr_en,
	input  logic [fmo_pkg::CFG_IDX_W-1:0]        wr_index,
	input  logic [fmo_pkg::CFG_DAT_W-1:0]        wr_data
);
	import fmo_pkg::*;

	localparam int AW    = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
	localparam int CNT_W = $clog2(MAX_VOICES + 1);
	localparam int SUM_W = SAMPLE_W + CNT_W;
	localparam int ENT_W = 2 * PHASE_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	// configuration
	logic                use_fm_q;
	logic [INDEX_W-1:0]  mod_index_q;
	logic [AMP_W-1:0]    amp_q;
	logic [NVOICE_W-1:0] nv_q;

	// control
	logic [1:0]       state_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] iss_q;
	logic [CNT_W-1:0] n_eff;
	logic             accept;
	logic             tick_acc;
	logic             load_acc;
	logic             issue;
	logic             pipe_busy;
	logic             mix_ready;
	logic             mix_start;
	logic [6:0]       vi_ext;
	logic             load_ok;
	logic [AW-1:0]    load_addr;
	logic [AW-1:0]    rd_addr;

	// voice memories and their valid bits
	logic [ENT_W-1:0]      ph_mem  [MAX_VOICES];
	logic [ENT_W-1:0]      inc_mem [MAX_VOICES];
	logic [MAX_VOICES-1:0] ph_vld_q;
	logic [MAX_VOICES-1:0] inc_vld_q;

	// pipeline
	logic                   v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [AW-1:0]          addr_s1;
	logic [ENT_W-1:0]       ph_rd_s1;
	logic [ENT_W-1:0]       inc_rd_s1;
	logic                   pv_s1;
	logic                   iv_s1;
	logic [PHASE_W-1:0]     ph_c, ph_m, inc_c, inc_m;
	logic [PHASE_W-1:0]     cp_s2, cp_s3, cp_s4;
	logic signed [SAMPLE_W-1:0] s_mod;
	logic signed [SAMPLE_W-1:0] s_car;
	logic signed [22:0]     p1_s3;
	logic signed [45:0]     p2_s4;
	logic [PHASE_W-1:0]     cp_fm;
	logic signed [SUM_W-1:0] sum_q;

	// handshake
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign tick_acc  = accept && (func == FUNC_TICK);
	assign load_acc  = accept && (func == FUNC_LOAD);
	assign issue     = (state_q == ST_RUN);
	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
	assign mix_start = (state_q == ST_WAIT) && !pipe_busy && mix_ready;

	assign vi_ext    = 7'(voice_index);
	assign load_ok   = (32'(vi_ext) < MAX_VOICES);
	assign load_addr = vi_ext[AW-1:0];
	assign rd_addr   = iss_q[AW-1:0];

	// clamp the voice count
	always_comb begin
		if (nv_q == '0)
			n_eff = CNT_W'(1);
		else if (32'(nv_q) > MAX_VOICES)
			n_eff = CNT_W'(MAX_VOICES);
		else
			n_eff = CNT_W'(nv_q);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_fm_q    <= 1'b0;
			mod_index_q <= '0;
			amp_q       <= AMP_RESET;
			nv_q        <= NVOICE_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_USE_FM:     use_fm_q    <= wr_data[0];
				CFG_MOD_INDEX:  mod_index_q <= wr_data[INDEX_W-1:0];
				CFG_AMP:        amp_q       <= wr_data[AMP_W-1:0];
				CFG_NUM_VOICES: nv_q        <= wr_data[NVOICE_W-1:0];
			endcase
		end
	end

	// sequencer: issue one voice per cycle, then drain and hand off the sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iss_q   <= '0;
			n_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (tick_acc) begin
						state_q <= ST_RUN;
						iss_q   <= '0;
						n_q     <= n_eff;
					end
				end
				ST_RUN: begin
					iss_q <= iss_q + 1'b1;
					if (iss_q == n_q - 1'b1)
						state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (mix_start)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// valid bits: unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_vld_q  <= '0;
			inc_vld_q <= '0;
		end else begin
			if (v_s1)
				ph_vld_q[addr_s1] <= 1'b1;
			if (load_acc && load_ok)
				inc_vld_q[load_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		pv_s1   <= ph_vld_q[rd_addr];
		iv_s1   <= inc_vld_q[rd_addr];
		addr_s1 <= rd_addr;
	end

	// phase memory: read at issue, write back advanced phases in the next cycle
	always_ff @(posedge clk) begin
		if (v_s1)
			ph_mem[addr_s1] <= {ph_c + inc_c, ph_m + inc_m};
		ph_rd_s1 <= ph_mem[rd_addr];
	end

	// step memory: written by loads, read at issue
	always_ff @(posedge clk) begin
		if (load_acc && load_ok)
			inc_mem[load_addr] <= {carrier_step, mod_step};
		inc_rd_s1 <= inc_mem[rd_addr];
	end

	// mask never-written entries
	assign ph_c  = pv_s1 ? ph_rd_s1[ENT_W-1 -: PHASE_W] : '0;
	assign ph_m  = pv_s1 ? ph_rd_s1[PHASE_W-1:0] : '0;
	assign inc_c = iv_s1 ? inc_rd_s1[ENT_W-1 -: PHASE_W] : '0;
	assign inc_m = iv_s1 ? inc_rd_s1[PHASE_W-1:0] : '0;

	// modulator sine, ready in stage 2
	fmo_sine #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_mod_sine (
		.clk  (clk),
		.phase(ph_m),
		.sine (s_mod)
	);

	// FM offset: index * sine, then radians to phase units
	always_ff @(posedge clk) begin
		cp_s2 <= ph_c;
		cp_s3 <= cp_s2;
		cp_s4 <= cp_s3;
		p1_s3 <= 23'($signed({17'd0, mod_index_q}) * $signed({{7{s_mod[SAMPLE_W-1]}}, s_mod}));
		p2_s4 <= p1_s3 * TURN_PER_RADIAN;
	end

	// floor of the Q15 offset, modulo one turn
	assign cp_fm = use_fm_q ? (cp_s4 + p2_s4[PHASE_W+14:15]) : cp_s4;

	// carrier sine, ready in stage 5
	fmo_sine #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_car_sine (
		.clk  (clk),
		.phase(cp_fm),
		.sine (s_car)
	);

	// accumulate the voices
	always_ff @(posedge clk) begin
		if (tick_acc)
			sum_q <= '0;
		else if (v_s5)
			sum_q <= sum_q + SUM_W'(s_car);
	end

	fmo_scale #(
		.SUM_W(SUM_W),
		.CNT_W(CNT_W)
	) u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mix_start),
		.sum      (sum_q),
		.amp      (amp_q),
		.nv       (n_q),
		.ready    (mix_ready),
		.sample   (sample),
		.out_valid(out_valid),
		.out_stall(out_stall)
	);

	// no voice in flight while a new word can be taken
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !pipe_busy)
		else $error("voice pipeline busy while input open");

	// write-back stays within the active voices
	a_wb_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (CNT_W'(addr_s1) < n_q))
		else $error("phase write-back beyond active voices");

	// a load leaves the input open
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |=> !in_stall)
		else $error("load word did not complete");

endmodule

>>> sv/fmo_sine.sv
// ----------------------------------------------------------------------------
// fmo_sine
// Phase to Q15 sine through a synchronous quarter-wave ROM; the ROM read is registered.
// ----------------------------------------------------------------------------
module fmo_sine #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                           clk,
	input  logic [fmo_pkg::PHASE_W-1:0]    phase,
	output logic signed [fmo_pkg::SAMPLE_W-1:0] sine
);
	import fmo_pkg::*;

	localparam int QB    = SINE_TABLE_BITS - 2;
	localparam int QSIZE = 1 << QB;
	localparam logic [QB:0] QTOP = (QB + 1)'(1) << QB;

	logic [SINE_TABLE_BITS-1:0] idx;
	logic [1:0]                 quad;
	logic [QB-1:0]              j;
	logic [QB:0]                addr;
	logic [ROM_W-1:0]           rom_c [QSIZE + 1];
	logic [ROM_W-1:0]           rom_q;
	logic                       neg_q;

	// build the quarter-wave table at elaboration
	for (genvar k = 0; k <= QSIZE; k++) begin : g_rom
		assign rom_c[k] = quarter_rom(k, SINE_TABLE_BITS);
	end

	// fold the phase into the first quadrant
	assign idx  = phase[PHASE_W-1 -: SINE_TABLE_BITS];
	assign quad = idx[SINE_TABLE_BITS-1 -: 2];
	assign j    = idx[QB-1:0];
	assign addr = quad[0] ? (QTOP - {1'b0, j}) : {1'b0, j};

	// registered ROM read
	always_ff @(posedge clk) begin
		rom_q <= rom_c[addr];
		neg_q <= quad[1];
	end

	// negate the lower half-wave
	assign sine = neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

endmodule

>>> sv/fmo_scale.sv
// ----------------------------------------------------------------------------
// fmo_scale
// Scale the voice sum by amplitude / (voices * 100) with a bit-serial
// restoring divider, saturate to Q1.15 and hold the sample for the output.
// ----------------------------------------------------------------------------
module fmo_scale #(
	parameter int SUM_W = 22,
	parameter int CNT_W = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [SUM_W-1:0]           sum,
	input  logic [fmo_pkg::AMP_W-1:0]         amp,
	input  logic [CNT_W-1:0]                  nv,
	output logic                              ready,
	output logic signed [fmo_pkg::SAMPLE_W-1:0] sample,
	output logic                              out_valid,
	input  logic                              out_stall
);
	import fmo_pkg::*;

	localparam int PW = SUM_W + AMP_W;
	localparam int DW = CNT_W + 7;
	localparam int IW = $clog2(PW + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PREP = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]          state_q;
	logic                neg_q;
	logic [SUM_W-1:0]    mag_q;
	logic [AMP_W-1:0]    amp_q;
	logic [CNT_W-1:0]    nv_q;
	logic [PW-1:0]       dvd_q;
	logic [DW-1:0]       dvs_q;
	logic [DW-1:0]       rem_q;
	logic [IW-1:0]       cnt_q;
	logic [DW:0]         rem_sh;
	logic                fits;
	logic                slot_free;
	logic                over;
	logic [SAMPLE_W-1:0] sat;

	assign ready     = (state_q == S_IDLE);
	assign rem_sh    = {rem_q, dvd_q[PW-1]};
	assign fits      = (rem_sh >= {1'b0, dvs_q});
	assign slot_free = !out_valid || !out_stall;

	// saturate the quotient held in dvd_q
	always_comb begin
		over = neg_q ? (dvd_q > PW'(32768)) : (dvd_q > PW'(32767));
		if (over)
			sat = neg_q ? 16'h8000 : 16'h7fff;
		else
			sat = neg_q ? (16'd0 - dvd_q[SAMPLE_W-1:0]) : dvd_q[SAMPLE_W-1:0];
	end

	// sequence the divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start)
						state_q <= S_PREP;
				end
				S_PREP: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == '0)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
			endcase
		end
	end

	// operands, shift-subtract step
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			neg_q <= sum[SUM_W-1];
			mag_q <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
			amp_q <= amp;
			nv_q  <= nv;
		end
		if (state_q == S_PREP) begin
			dvd_q <= PW'(mag_q * amp_q);
			dvs_q <= DW'(nv_q * 7'd100);
			rem_q <= '0;
			cnt_q <= IW'(PW - 1);
		end
		if (state_q == S_DIV) begin
			rem_q <= fits ? DW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DW-1:0];
			dvd_q <= {dvd_q[PW-2:0], fits};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// hold the output word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == S_DONE && slot_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && slot_free)
			sample <= $signed(sat);
	end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-voice FM oscillator. A short table of
// directed words runs first, then phases of random load and tick words under
// changing register settings. Both handshake sides idle at random, and the
// sample side holds off once for a long stretch. Every sample is checked
// against a value typed in the table or against a bit-exact predictor of the
// voice phases, the sine table and the mixer.
// ----------------------------------------------------------------------------
module tb;
	import fmo_pkg::*;

	localparam int NVOICE_MAX = 32;
	localparam int TBL_BITS = 10;
	localparam int QSIZE = 1 << (TBL_BITS - 2);
	localparam longint unsigned HALF_PI_Q = 64'd1686629713;
	localparam longint RAD_PHASE = 64'sd2670177;
	localparam int SETTLE_CYCLES = 120;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 75;
	localparam int NUM_PHASES = 8;
	localparam int DIR_ROWS = 32;

	typedef enum logic [1:0] {ROW_TICK, ROW_LOAD, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                  kind;
		logic [VIDX_W-1:0]          voice;
		logic [PHASE_W-1:0]         cstep;
		logic [PHASE_W-1:0]         mstep;
		logic [CFG_IDX_W-1:0]       reg_sel;
		logic [CFG_DAT_W-1:0]       reg_val;
		logic                       typed;
		logic signed [SAMPLE_W-1:0] want;
	} row_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic                       func;
	logic [VIDX_W-1:0]          voice_index;
	logic [PHASE_W-1:0]         carrier_step;
	logic [PHASE_W-1:0]         mod_step;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       wr_en;
	logic [CFG_IDX_W-1:0]       wr_index;
	logic [CFG_DAT_W-1:0]       wr_data;

	// predictor state: voice phases, steps and the register copies
	logic [PHASE_W-1:0] car_ph [NVOICE_MAX];
	logic [PHASE_W-1:0] mod_ph [NVOICE_MAX];
	logic [PHASE_W-1:0] car_inc [NVOICE_MAX];
	logic [PHASE_W-1:0] mod_inc [NVOICE_MAX];
	logic               fm_on;
	logic [INDEX_W-1:0] fm_depth;
	logic [AMP_W-1:0]   gain_pct;
	logic [NVOICE_W-1:0] voice_count;
	int                 qwave [QSIZE + 1];

	logic signed [SAMPLE_W-1:0] pending_samples [$];
	int mismatch_count = 0;
	int samples_seen = 0;
	int calm_items = 0;

	multi_voice_fm_oscillator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.voice_index  (voice_index),
		.carrier_step (carrier_step),
		.mod_step     (mod_step),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample       (sample),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	always #5 clk = ~clk;

	// Quarter-wave entry k in Q15: Taylor series in Q30, truncating steps
	function automatic int quarter_entry(int unsigned k);
		longint unsigned one;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned p;
		longint unsigned v;
		one = 64'd1 << 30;
		x = (64'(k) * HALF_PI_Q) >> (TBL_BITS - 2);
		x2 = (x * x) >> 30;
		p = one - x2 / 72;
		p = one - (((x2 / 42) * p) >> 30);
		p = one - (((x2 / 20) * p) >> 30);
		p = one - (((x2 / 6) * p) >> 30);
		v = (x * p) >> 30;
		v = (v + (64'd1 << 14)) >> 15;
		if (v > 32767)
			v = 32767;
		return int'(v);
	endfunction

	// Table sine of a 24-bit phase: top bits pick quadrant and entry
	function automatic int sine_of(logic [PHASE_W-1:0] ph);
		logic [TBL_BITS-1:0] idx;
		int j;
		int v;
		idx = ph[PHASE_W-1 -: TBL_BITS];
		j = int'(idx[TBL_BITS-3:0]);
		v = idx[TBL_BITS-2] ? qwave[QSIZE - j] : qwave[j];
		return idx[TBL_BITS-1] ? -v : v;
	endfunction

	// Mix one tick over the active voices, then advance their phases
	function automatic logic signed [SAMPLE_W-1:0] mix_tick();
		int n;
		int sum;
		int s;
		longint off;
		longint acc;
		longint r;
		longint unsigned mag;
		longint unsigned q;
		logic [PHASE_W-1:0] cp;
		n = int'(voice_count);
		if (n == 0)
			n = 1;
		if (n > NVOICE_MAX)
			n = NVOICE_MAX;
		sum = 0;
		for (int v = 0; v < n; v++) begin
			cp = car_ph[v];
			if (fm_on) begin
				s = sine_of(mod_ph[v]);
				off = (longint'(fm_depth) * longint'(s) * RAD_PHASE) >>> 15;
				acc = longint'(cp) + off;
				cp = acc[PHASE_W-1:0];
			end
			sum += sine_of(cp);
			car_ph[v] = car_ph[v] + car_inc[v];
			mod_ph[v] = mod_ph[v] + mod_inc[v];
		end
		mag = (sum < 0) ? 64'(-sum) : 64'(sum);
		q = (mag * gain_pct) / (64'(n) * 100);
		if (sum < 0) begin
			if (q > 32768)
				r = -32768;
			else
				r = -longint'(q);
		end else begin
			if (q > 32767)
				r = 32767;
			else
				r = longint'(q);
		end
		return r[SAMPLE_W-1:0];
	endfunction

	// Gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [PHASE_W-1:0] pick_step();
		case ($urandom_range(0, 3))
			0: return PHASE_W'($urandom);
			1: return PHASE_W'($urandom_range(0, 4095));
			2: return PHASE_W'($urandom_range(0, 1023)) << 14;
			default: return 24'hFFFFFF - PHASE_W'($urandom_range(0, 4095));
		endcase
	endfunction

	task automatic report_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Offer one word, wait for it to be taken, then update the predictor
	task automatic send_word(logic f, logic [VIDX_W-1:0] vi, logic [PHASE_W-1:0] cs,
		logic [PHASE_W-1:0] ms, logic typed, logic signed [SAMPLE_W-1:0] want);
		logic stalled;
		logic signed [SAMPLE_W-1:0] predicted;
		in_valid <= 1'b1;
		func <= f;
		voice_index <= vi;
		carrier_step <= cs;
		mod_step <= ms;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		if (f == FUNC_LOAD) begin
			car_inc[vi] = cs;
			mod_inc[vi] = ms;
		end else begin
			predicted = mix_tick();
			pending_samples.push_back(typed ? want : predicted);
		end
	endtask

	// Idle the sender between words, with calm stretches of back-to-back words
	task automatic pause_sender();
		int gap;
		if (calm_items > 0) begin
			calm_items--;
			gap = 0;
		end else if ($urandom_range(0, 19) == 0) begin
			calm_items = $urandom_range(10, 40);
			gap = 0;
		end else begin
			gap = pick_gap();
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid, drain all samples, then let a pending divide finish
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DAT_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= sel;
		wr_data <= val;
		@(posedge clk);
		case (sel)
			CFG_USE_FM: fm_on = val[0];
			CFG_MOD_INDEX: fm_depth = val[INDEX_W-1:0];
			CFG_AMP: gain_pct = val[AMP_W-1:0];
			default: voice_count = val[NVOICE_W-1:0];
		endcase
	endtask

	// Check each taken sample against the oldest expectation
	initial begin : result_monitor
		logic seen_valid;
		logic seen_stall;
		logic signed [SAMPLE_W-1:0] seen_sample;
		logic signed [SAMPLE_W-1:0] want;
		forever begin
			@(negedge clk);
			seen_valid = out_valid;
			seen_stall = out_stall;
			seen_sample = sample;
			@(posedge clk);
			if (arst_n === 1'b1 && seen_valid === 1'b1 && seen_stall === 1'b0) begin
				samples_seen++;
				if (pending_samples.size() == 0) begin
					report_mismatch($sformatf("sample %0d with none expected", seen_sample));
				end else begin
					want = pending_samples.pop_front();
					if (seen_sample !== want)
						report_mismatch($sformatf("sample %0d, expected %0d",
							seen_sample, want));
				end
			end
		end
	end

	// Drive the sample-side stall: random bursts, calm stretches, one long hold
	initial begin : result_drain
		int hold_left;
		int stall_left;
		int calm_left;
		logic hold_done;
		logic next_stall;
		hold_left = 0;
		stall_left = 0;
		calm_left = 0;
		hold_done = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && samples_seen >= 60) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				next_stall = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				next_stall = 1'b1;
			end else begin
				next_stall = 1'b0;
				if (calm_left > 0)
					calm_left--;
				else if ($urandom_range(0, 7) == 0)
					calm_left = $urandom_range(50, 200);
				else
					stall_left = pick_gap();
			end
			@(posedge clk);
			out_stall <= next_stall;
		end
	end

	initial begin : stimulus
		row_t steps_tbl [DIR_ROWS];
		int eff_n;
		logic f;
		logic [VIDX_W-1:0] vi;
		logic [INDEX_W-1:0] depth_val;
		logic [AMP_W-1:0] amp_val;
		logic [NVOICE_W-1:0] count_val;
		logic fm_val;

		// hold every input at a known value through reset
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		func <= FUNC_TICK;
		voice_index <= '0;
		carrier_step <= '0;
		mod_step <= '0;
		wr_en <= 1'b0;
		wr_index <= CFG_USE_FM;
		wr_data <= '0;

		for (int k = 0; k <= QSIZE; k++)
			qwave[k] = quarter_entry(k);
		for (int v = 0; v < NVOICE_MAX; v++) begin
			car_ph[v] = '0;
			mod_ph[v] = '0;
			car_inc[v] = '0;
			mod_inc[v] = '0;
		end
		fm_on = 1'b0;
		fm_depth = '0;
		gain_pct = AMP_RESET;
		voice_count = NVOICE_RESET;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// quarter-turn steps on voice 0 walk the four quadrant points
		steps_tbl = '{
			'{ROW_TICK, 0, 0, 0, CFG_USE_FM, 0, 1, 0},
			'{ROW_LOAD, 0, 24'h400000, 24'h000000, CFG_USE_FM, 0, 0, 0},
			'{ROW_TICK, 0, 0, 0, CFG_USE_FM, 0, 1, 0},
			'{ROW_TICK, 0, 0, 0, CFG_USE_FM, 0, 1, 6553},
			'{ROW_TICK, 0, 0, 0, CFG_USE_FM, 0, 1, 0},
			'{ROW_TICK, 0, 0, 0, CFG_USE_FM, 0, 1, -6553},
			'{ROW_LOAD, 31, 24'hFFFFFF, 24'hFFFFFF, CFG_USE_FM, 0, 0, 0},
			'{ROW_CFG, 0, 0, 0, CFG_AMP, 127, 0, 0},
			'{ROW_TICK, 0, 0, 0, CFG_USE_FM, 0, 1, 0},
			'{ROW_TICK, 0, 0, 0, CFG_USE_FM, 0, 1, 32767},
			'{ROW_TICK, 0, 0, 0, CFG_USE_FM, 0, 1, 0},
			'{ROW_TICK, 0, 0, 0, CFG_USE_FM, 0, 1, -32768},
			'{ROW_CFG, 0, 0, 0, CFG_NUM_VOICES, 63, 0, 0},
			'{ROW_CFG, 0, 0, 0, CFG_USE_FM, 1, 0, 0},
			'{ROW_CFG, 0, 0, 0, CFG_MOD_INDEX, 63, 0, 0},
			'{ROW_CFG, 0, 0, 0, CFG_AMP, 100, 0, 0},
			'{ROW_LOAD, 1, 24'h123456, 24'h3ABCDE, CFG_USE_FM, 0, 0, 0},
			'{ROW_TICK, 0, 0, 0, CFG_USE_FM, 0, 0, 0},
			'{ROW_TICK, 0, 0, 0, CFG_USE_FM, 0, 0, 0},
			'{ROW_TICK, 0, 0, 0, CFG_USE_FM, 0, 0, 0},
			'{ROW_CFG, 0, 0, 0, CFG_NUM_VOICES, 0, 0, 0},
			'{ROW_CFG, 0, 0, 0, CFG_MOD_INDEX, 50, 0, 0},
			'{ROW_TICK, 0, 0, 0, CFG_USE_FM, 0, 0, 0},
			'{ROW_TICK, 0, 0, 0, CFG_USE_FM, 0, 0, 0},
			'{ROW_CFG, 0, 0, 0, CFG_AMP, 0, 0, 0},
			'{ROW_TICK, 0, 0, 0, CFG_USE_FM, 0, 1, 0},
			'{ROW_CFG, 0, 0, 0, CFG_USE_FM, 0, 0, 0},
			'{ROW_CFG, 0, 0, 0, CFG_AMP, 20, 0, 0},
			'{ROW_LOAD, 16, 24'hAAAAAA, 24'h555555, CFG_USE_FM, 0, 0, 0},
			'{ROW_TICK, 0, 0, 0, CFG_USE_FM, 0, 0, 0},
			'{ROW_LOAD, 0, 24'h000000, 24'hFFFFFF, CFG_USE_FM, 0, 0, 0},
			'{ROW_TICK, 0, 0, 0, CFG_USE_FM, 0, 0, 0}
		};

		// walk the directed table
		foreach (steps_tbl[r]) begin
			case (steps_tbl[r].kind)
				ROW_CFG: begin
					settle();
					write_reg(steps_tbl[r].reg_sel, steps_tbl[r].reg_val);
					wr_en <= 1'b0;
				end
				ROW_LOAD: begin
					send_word(FUNC_LOAD, steps_tbl[r].voice, steps_tbl[r].cstep,
						steps_tbl[r].mstep, 1'b0, '0);
					pause_sender();
				end
				default: begin
					send_word(FUNC_TICK, steps_tbl[r].voice, steps_tbl[r].cstep,
						steps_tbl[r].mstep, steps_tbl[r].typed, steps_tbl[r].want);
					pause_sender();
				end
			endcase
		end

		// random phases, each under its own register setting
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin
					fm_val = 1'b1;
					depth_val = 50;
					amp_val = 100;
					count_val = 32;
				end
				1: begin
					fm_val = 1'b1;
					depth_val = 63;
					amp_val = 127;
					count_val = 63;
				end
				2: begin
					fm_val = 1'b0;
					depth_val = 0;
					amp_val = 73;
					count_val = 0;
				end
				3: begin
					fm_val = 1'b1;
					depth_val = INDEX_W'($urandom_range(0, 63));
					amp_val = AMP_W'($urandom_range(0, 100));
					count_val = 2;
				end
				default: begin
					fm_val = 1'($urandom_range(0, 1));
					depth_val = INDEX_W'($urandom_range(0, 63));
					amp_val = ($urandom_range(0, 4) == 0) ? AMP_W'($urandom_range(101, 127))
						: AMP_W'($urandom_range(0, 100));
					count_val = ($urandom_range(0, 9) < 7) ? NVOICE_W'($urandom_range(1, 4))
						: NVOICE_W'($urandom_range(0, 63));
				end
			endcase
			settle();
			write_reg(CFG_USE_FM, CFG_DAT_W'(fm_val));
			write_reg(CFG_MOD_INDEX, CFG_DAT_W'(depth_val));
			write_reg(CFG_AMP, CFG_DAT_W'(amp_val));
			write_reg(CFG_NUM_VOICES, CFG_DAT_W'(count_val));
			wr_en <= 1'b0;
			eff_n = (count_val == 0) ? 1 : ((count_val > NVOICE_MAX) ? NVOICE_MAX : count_val);

			// loads mostly aim at active voices
			repeat (PHASE_ITEMS) begin
				f = ($urandom_range(0, 99) < 30) ? FUNC_LOAD : FUNC_TICK;
				vi = ($urandom_range(0, 99) < 80) ? VIDX_W'($urandom_range(0, eff_n - 1))
					: VIDX_W'($urandom_range(0, 31));
				send_word(f, vi, pick_step(), pick_step(), 1'b0, '0);
				pause_sender();
			end
		end

		settle();
		if (mismatch_count == 0 && pending_samples.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// bound the run
	initial begin : watchdog
		#(10_000_000);
		$display("Some tests failed");
		$finish;
	end

endmodule
